/* hw/rtl/ptcam_pkg.sv */
// Shared types, codes and helpers for the prefix TCAM table.
// No dependencies; every other file but ptcam_ram imports this package.
package ptcam_pkg;

    localparam int DEPTH = 64;
    localparam int WIDTH = 32;
    localparam int AW    = 6;              // row address bits
    localparam int CW    = 7;              // occupied count bits (0..DEPTH)
    localparam int LW    = 6;              // entry length bits
    localparam int RW    = WIDTH + LW;     // stored word: bits then length

    localparam logic [2:0] K_PREFIX     = 3'd0;
    localparam logic [2:0] K_EXACT      = 3'd1;
    localparam logic [2:0] K_OVERWRITE  = 3'd2;
    localparam logic [2:0] K_INSERT     = 3'd3;
    localparam logic [2:0] K_INVALIDATE = 3'd4;
    localparam logic [2:0] K_REMOVE     = 3'd5;
    localparam logic [2:0] K_READ       = 3'd6;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_WIDE   = 2'd2;
    localparam logic [1:0] ST_BEYOND = 2'd3;

    localparam logic CFG_ROWS  = 1'b0;
    localparam logic CFG_WIDTH = 1'b1;

    typedef struct packed {
        logic [2:0]       kind;
        logic [WIDTH-1:0] key_bits;
        logic [LW-1:0]    key_length;
        logic [AW-1:0]    position;
    } t_in;

    typedef struct packed {
        logic [1:0]       status;
        logic             hit;
        logic [AW-1:0]    match_index;
        logic [WIDTH-1:0] read_bits;
        logic [LW-1:0]    read_length;
    } t_out;

    typedef enum logic [1:0] {RA_ROW, RA_ROW_M1, RA_ROW_P1, RA_POS} t_raddr_sel;
    typedef enum logic [1:0] {RI_ZERO, RI_COUNT, RI_POS} t_row_init;

    typedef struct packed {
        logic       load;
        logic       decode;
        logic       rd_en;
        t_raddr_sel rd_sel;
        logic       shift_wr;
        logic       put;
        logic       row_load;
        t_row_init  row_init;
        logic       row_inc;
        logic       row_dec;
        logic       set_hit;
        logic       capture;
        logic       remove_done;
        logic       publish;
    } t_cmd;

    typedef struct packed {
        logic [2:0] kind;
        logic       wr_err;
        logic       pos_in;
        logic       pos_valid;
        logic       count_zero;
        logic       row_eq_pos;
        logic       row_last;
        logic       match;
        logic       out_free;
    } t_stat;

    function automatic logic [WIDTH-1:0] lead_mask(input logic [LW-1:0] len);
        logic [WIDTH-1:0] ones;
        ones = '1;
        if (len >= LW'(WIDTH)) begin
            return ones;
        end
        return ones & ~(ones >> len);
    endfunction

endpackage

/* hw/rtl/ptcam_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptcam_ram #(
    parameter int W = 38,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* hw/rtl/ptcam_ctrl.sv */
// Sequencer for the prefix TCAM table: walks rows for searches and shifts.
// Depends on ptcam_pkg.
module ptcam_ctrl import ptcam_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_stall,
    output t_cmd  o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_SRD, S_SCMP, S_IRD, S_IWR, S_WPOS,
        S_RRD, S_RWR, S_READ, S_RCAP, S_FIN
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                o_cmd.decode = 1'b1;
                n_state      = S_FIN;
                unique case (i_stat.kind)
                    K_PREFIX, K_EXACT: begin
                        if (!i_stat.count_zero) begin
                            o_cmd.row_load = 1'b1;
                            o_cmd.row_init = RI_ZERO;
                            n_state        = S_SRD;
                        end
                    end
                    K_OVERWRITE, K_INSERT: begin
                        if (!i_stat.wr_err) begin
                            if (i_stat.kind == K_INSERT && i_stat.pos_in) begin
                                o_cmd.row_load = 1'b1;
                                o_cmd.row_init = RI_COUNT;
                                n_state        = S_IRD;
                            end else begin
                                n_state = S_WPOS;
                            end
                        end
                    end
                    K_REMOVE: begin
                        if (i_stat.pos_in) begin
                            o_cmd.row_load = 1'b1;
                            o_cmd.row_init = RI_POS;
                            n_state        = S_RRD;
                        end
                    end
                    K_READ: begin
                        if (i_stat.pos_in && i_stat.pos_valid) begin
                            n_state = S_READ;
                        end
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_SRD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RA_ROW;
                n_state      = S_SCMP;
            end
            S_SCMP: begin
                priority if (i_stat.match) begin
                    o_cmd.set_hit = 1'b1;
                    n_state       = S_FIN;
                end else if (i_stat.row_last) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.row_inc = 1'b1;
                    n_state       = S_SRD;
                end
            end
            S_IRD: begin
                if (i_stat.row_eq_pos) begin
                    n_state = S_WPOS;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RA_ROW_M1;
                    n_state      = S_IWR;
                end
            end
            S_IWR: begin
                o_cmd.shift_wr = 1'b1;
                o_cmd.row_dec  = 1'b1;
                n_state        = S_IRD;
            end
            S_WPOS: begin
                o_cmd.put = 1'b1;
                n_state   = S_FIN;
            end
            S_RRD: begin
                if (i_stat.row_last) begin
                    o_cmd.remove_done = 1'b1;
                    n_state           = S_FIN;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RA_ROW_P1;
                    n_state      = S_RWR;
                end
            end
            S_RWR: begin
                o_cmd.shift_wr = 1'b1;
                o_cmd.row_inc  = 1'b1;
                n_state        = S_RRD;
            end
            S_READ: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RA_POS;
                n_state      = S_RCAP;
            end
            S_RCAP: begin
                o_cmd.capture = 1'b1;
                n_state       = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
endmodule

/* hw/rtl/ptcam_dpath.sv */
// Datapath of the prefix TCAM table: row RAM, valid bits, count, limits,
// compare logic and result registers. Depends on ptcam_pkg and ptcam_ram.
module ptcam_dpath import ptcam_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    input  t_in           i_in,
    input  logic          i_cfg_valid,
    input  logic          i_cfg_index,
    input  logic [CW-1:0] i_cfg_data,
    input  logic          i_out_stall,
    output t_stat         o_stat,
    output t_out          o_out,
    output logic          o_out_valid
);
    logic [CW-1:0]    r_rows_cfg, n_rows_cfg;
    logic [LW-1:0]    r_width_cfg, n_width_cfg;
    logic [DEPTH-1:0] r_valid, n_valid;
    logic [CW-1:0]    r_occ, n_occ;
    logic             r_out_valid, n_out_valid;
    t_in              r_op;
    logic [AW-1:0]    r_row;
    t_out             r_res;
    t_out             r_out;

    logic [CW-1:0]    lim, pos_ext;
    logic [LW-1:0]    wlim, slen;
    logic             pos_in, adds;
    logic [1:0]       wstatus;
    logic [RW-1:0]    rdata, wdata;
    logic [WIDTH-1:0] rd_bits, key_stored;
    logic [LW-1:0]    rd_len;
    logic             pm, em;
    logic [AW-1:0]    raddr, waddr;
    logic             we;

    assign lim     = (r_rows_cfg > CW'(DEPTH)) ? CW'(DEPTH) : r_rows_cfg;
    assign wlim    = (r_width_cfg > LW'(WIDTH)) ? LW'(WIDTH) : r_width_cfg;
    assign slen    = (r_op.key_length > LW'(WIDTH)) ? LW'(WIDTH) : r_op.key_length;
    assign pos_ext = {1'b0, r_op.position};
    assign pos_in  = pos_ext < r_occ;
    assign adds    = (r_op.kind == K_INSERT) || !pos_in;

    always_comb begin
        wstatus = ST_OK;
        if (r_op.kind == K_OVERWRITE || r_op.kind == K_INSERT) begin
            priority if (pos_ext >= lim) begin
                wstatus = ST_BEYOND;
            end else if (adds && r_occ >= lim) begin
                wstatus = ST_FULL;
            end else if (r_op.key_length > wlim) begin
                wstatus = ST_WIDE;
            end else begin
                wstatus = ST_OK;
            end
        end
    end

    assign rd_bits    = rdata[RW-1:LW];
    assign rd_len     = rdata[LW-1:0];
    assign key_stored = r_op.key_bits & lead_mask(r_op.key_length);
    assign pm = (rd_len <= slen) &&
                (((r_op.key_bits ^ rd_bits) & lead_mask(rd_len)) == '0);
    assign em = (r_op.key_length <= LW'(WIDTH)) && (rd_len == r_op.key_length) &&
                (key_stored == rd_bits);

    always_comb begin
        unique case (i_cmd.rd_sel)
            RA_ROW:    raddr = r_row;
            RA_ROW_M1: raddr = r_row - AW'(1);
            RA_ROW_P1: raddr = r_row + AW'(1);
            RA_POS:    raddr = r_op.position;
            default:   raddr = r_row;
        endcase
    end

    assign we    = i_cmd.shift_wr || i_cmd.put;
    assign waddr = i_cmd.put ? r_op.position : r_row;
    assign wdata = i_cmd.put ? {key_stored, r_op.key_length} : rdata;

    ptcam_ram #(.W(RW), .D(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        o_stat.kind       = r_op.kind;
        o_stat.wr_err     = (wstatus != ST_OK);
        o_stat.pos_in     = pos_in;
        o_stat.pos_valid  = r_valid[r_op.position];
        o_stat.count_zero = (r_occ == '0);
        o_stat.row_eq_pos = (r_row == r_op.position);
        o_stat.row_last   = ({1'b0, r_row} + CW'(1)) >= r_occ;
        o_stat.match      = r_valid[r_row] && ((r_op.kind == K_PREFIX) ? pm : em);
        o_stat.out_free   = !r_out_valid || !i_out_stall;
    end

    // Valid bits, count, limits and the output valid flag.
    always_comb begin
        n_valid     = r_valid;
        n_occ       = r_occ;
        n_rows_cfg  = r_rows_cfg;
        n_width_cfg = r_width_cfg;
        n_out_valid = r_out_valid;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ROWS:  n_rows_cfg  = i_cfg_data;
                CFG_WIDTH: n_width_cfg = i_cfg_data[LW-1:0];
                default:   n_rows_cfg  = r_rows_cfg;
            endcase
        end

        if (i_cmd.decode && pos_in) begin
            if (r_op.kind == K_INVALIDATE) begin
                n_valid[r_op.position] = 1'b0;
            end
            if (r_op.kind == K_INSERT && wstatus == ST_OK) begin
                for (int i = 1; i < DEPTH; i++) begin
                    if (CW'(i) > pos_ext && CW'(i) <= r_occ) begin
                        n_valid[i] = r_valid[i-1];
                    end
                end
            end
            if (r_op.kind == K_REMOVE) begin
                for (int i = 0; i < DEPTH - 1; i++) begin
                    if (CW'(i) >= pos_ext && CW'(i) + CW'(1) < r_occ) begin
                        n_valid[i] = r_valid[i+1];
                    end
                end
                for (int i = 0; i < DEPTH; i++) begin
                    if (CW'(i) + CW'(1) == r_occ) begin
                        n_valid[i] = 1'b0;
                    end
                end
            end
        end

        if (i_cmd.put) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (CW'(i) >= r_occ && CW'(i) < pos_ext) begin
                    n_valid[i] = 1'b0;
                end
            end
            n_valid[r_op.position] = 1'b1;
            if (!pos_in) begin
                n_occ = pos_ext + CW'(1);
            end else if (r_op.kind == K_INSERT) begin
                n_occ = r_occ + CW'(1);
            end
        end

        if (i_cmd.remove_done) begin
            n_occ = r_occ - CW'(1);
        end

        if (i_cmd.publish) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_occ       <= '0;
            r_rows_cfg  <= CW'(64);
            r_width_cfg <= LW'(32);
            r_out_valid <= 1'b0;
        end else begin
            r_valid     <= n_valid;
            r_occ       <= n_occ;
            r_rows_cfg  <= n_rows_cfg;
            r_width_cfg <= n_width_cfg;
            r_out_valid <= n_out_valid;
        end
    end

    // Operation latch, row pointer and result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_in;
            r_res <= '0;
        end
        if (i_cmd.decode) begin
            r_res.status <= wstatus;
        end
        if (i_cmd.set_hit) begin
            r_res.hit         <= 1'b1;
            r_res.match_index <= r_row;
        end
        if (i_cmd.capture) begin
            r_res.read_bits   <= rd_bits;
            r_res.read_length <= rd_len;
        end
        if (i_cmd.row_load) begin
            unique case (i_cmd.row_init)
                RI_ZERO:  r_row <= '0;
                RI_COUNT: r_row <= r_occ[AW-1:0];
                RI_POS:   r_row <= r_op.position;
                default:  r_row <= '0;
            endcase
        end else if (i_cmd.row_inc) begin
            r_row <= r_row + AW'(1);
        end else if (i_cmd.row_dec) begin
            r_row <= r_row - AW'(1);
        end
        if (i_cmd.publish) begin
            r_out <= r_res;
        end
    end

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;
endmodule

/* hw/rtl/prefix_tcam_table_core.sv */
// Top level of the prefix TCAM table: sequencer plus datapath.
// Depends on ptcam_pkg, ptcam_ctrl, ptcam_dpath (and ptcam_ram below it).
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  ---------------------------
//  in        sink       i_in_valid/o_in_stall  t_in  (kind, key, length, pos)
//  out       source     o_out_valid/i_out_stall t_out (status, hit, index, read)
//  cfg       sink       i_cfg_valid/o_cfg_ready index 0 rows, 1 width; 7b data
//
// The sequencer takes one item at a time through the row RAM: a search reads each
// row and then compares it; an insert or remove with shift reads each row moved
// and then writes it one place along; a read reads the addressed row and then
// captures it; a write puts the entry at its position.
// Reset is synchronous and clears valid bits and the count and sets the limits
// back to 64 rows and width 32 at once; no clearing pass is needed since row
// contents are only seen through valid. A finished result waits in the output
// register under stall while the next transfer is accepted; the sequencer holds
// in its final state only while that register is occupied and stalled.
module prefix_tcam_table_core import ptcam_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  t_in           i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output t_out          o_out,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_index,
    input  logic [CW-1:0] i_cfg_data
);
    t_cmd  cmd;
    t_stat stat;

    // Hold the sequence of commands for one item at a time.
    ptcam_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // Row store, compares and result registers.
    ptcam_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out       (o_out),
        .o_out_valid (o_out_valid)
    );

    // Configuration writes are taken in any cycle.
    assign o_cfg_ready = 1'b1;
endmodule

/* hw/rtl/ptcam_checker.sv */
// Port-level checks for the prefix TCAM table, bound to the top level.
// Depends on ptcam_pkg.
module ptcam_checker import ptcam_pkg::*; (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input t_out          o_out
);
    // An accepted transfer occupies the sequencer in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not held off after transfer");

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled result changed");

    // A search hit never comes with an error or read data.
    a_hit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.hit) |->
        (o_out.status == ST_OK && o_out.read_bits == '0 && o_out.read_length == '0))
        else $error("hit result carries other fields");

    // A failed write reports no hit and no read data.
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status != ST_OK) |->
        (!o_out.hit && o_out.match_index == '0 && o_out.read_length == '0))
        else $error("error result carries other fields");

    // Stored lengths never exceed the entry width.
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.read_length <= LW'(WIDTH)))
        else $error("read length out of range");
endmodule

bind prefix_tcam_table_core ptcam_checker u_ptcam_checker (.*);

/* test/testbench.sv */
// Self-checking testbench for prefix_tcam_table_core: directed and random table traffic.
// Predicts each transfer in its own table copy; depends on ptcam_pkg and the RTL.
module testbench;
    import ptcam_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;  // cycles with no transfer anywhere
    localparam logic [2:0] K_NONE = 3'd7; // unused kind, no operation

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_stall;
    t_in           i_in;
    logic          o_out_valid;
    logic          i_out_stall;
    t_out          o_out;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic          i_cfg_index;
    logic [CW-1:0] i_cfg_data;

    prefix_tcam_table_core dut (.*);

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Shadow copy of the table and its limits
    logic [WIDTH-1:0] shadow_bits[DEPTH];
    logic [LW-1:0]    shadow_len[DEPTH];
    bit               shadow_valid[DEPTH];
    int               shadow_count;
    int               shadow_rows_cfg;
    int               shadow_width_cfg;

    t_out pending_results[$];
    bit   failed;
    int   send_gap_pct;
    int   stall_pct;
    int   hold_request;
    int   hold_left;
    int   quiet_cycles;
    logic [WIDTH-1:0] key_pool[8];

    function automatic logic [WIDTH-1:0] leading_ones(int len);
        if (len >= WIDTH) begin
            return '1;
        end
        return ~({WIDTH{1'b1}} >> len);
    endfunction

    // Work out the result of one operation and advance the shadow table
    task automatic table_predict(input t_in x, output t_out r);
        int lim;
        int wlim;
        int slen;
        int klen;
        int pos;
        bit adds;
        bit m;
        r    = '0;
        klen = x.key_length;
        pos  = x.position;
        lim  = (shadow_rows_cfg < DEPTH) ? shadow_rows_cfg : DEPTH;
        wlim = (shadow_width_cfg < WIDTH) ? shadow_width_cfg : WIDTH;
        case (x.kind)
            K_PREFIX, K_EXACT: begin
                slen = (klen < WIDTH) ? klen : WIDTH;
                for (int i = 0; i < shadow_count; i++) begin
                    if (!shadow_valid[i]) continue;
                    if (x.kind == K_PREFIX)
                        m = shadow_len[i] <= slen &&
                            ((x.key_bits ^ shadow_bits[i]) & leading_ones(shadow_len[i])) == 0;
                    else
                        m = klen <= WIDTH && shadow_len[i] == klen &&
                            (x.key_bits & leading_ones(klen)) == shadow_bits[i];
                    if (m) begin
                        r.hit = 1'b1;
                        r.match_index = AW'(i);
                        break;
                    end
                end
            end
            K_OVERWRITE, K_INSERT: begin
                adds = (x.kind == K_INSERT) || pos >= shadow_count;
                if (pos >= lim) begin
                    r.status = ST_BEYOND;
                end else if (adds && shadow_count >= lim) begin
                    r.status = ST_FULL;
                end else if (klen > wlim) begin
                    r.status = ST_WIDE;
                end else begin
                    if (pos >= shadow_count) begin
                        for (int i = shadow_count; i < pos; i++) begin
                            shadow_bits[i] = '0;
                            shadow_len[i] = '0;
                            shadow_valid[i] = 1'b0;
                        end
                        shadow_count = pos + 1;
                    end else if (x.kind == K_INSERT) begin
                        for (int i = shadow_count; i > pos; i--) begin
                            shadow_bits[i] = shadow_bits[i-1];
                            shadow_len[i] = shadow_len[i-1];
                            shadow_valid[i] = shadow_valid[i-1];
                        end
                        shadow_count++;
                    end
                    shadow_bits[pos] = x.key_bits & leading_ones(klen);
                    shadow_len[pos] = x.key_length;
                    shadow_valid[pos] = 1'b1;
                end
            end
            K_INVALIDATE: begin
                if (pos < shadow_count) shadow_valid[pos] = 1'b0;
            end
            K_REMOVE: begin
                if (pos < shadow_count) begin
                    for (int i = pos; i + 1 < shadow_count; i++) begin
                        shadow_bits[i] = shadow_bits[i+1];
                        shadow_len[i] = shadow_len[i+1];
                        shadow_valid[i] = shadow_valid[i+1];
                    end
                    shadow_count--;
                    shadow_bits[shadow_count] = '0;
                    shadow_len[shadow_count] = '0;
                    shadow_valid[shadow_count] = 1'b0;
                end
            end
            K_READ: begin
                if (pos < shadow_count && shadow_valid[pos]) begin
                    r.read_bits = shadow_bits[pos];
                    r.read_length = shadow_len[pos];
                end
            end
            default: ;
        endcase
    endtask

    function automatic t_in op(logic [2:0] kind, logic [WIDTH-1:0] key, int len, int pos);
        t_in x;
        x.kind = kind;
        x.key_bits = key;
        x.key_length = LW'(len);
        x.position = AW'(pos);
        return x;
    endfunction

    // Offer one item, with an optional random gap first; valid stays high on
    // acceptance so back-to-back transfers never lower and raise it in one step
    task automatic send_op(input t_in x);
        t_out r;
        if ($urandom_range(0, 99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in <= x;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        table_predict(x, r);
        pending_results.push_back(r);
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic drain;
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // One register write; valid drops for a cycle before the next write
    task automatic write_reg(input logic index, input int value);
        i_cfg_index <= index;
        i_cfg_data <= CW'(value);
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (index == CFG_ROWS) shadow_rows_cfg = value & 8'h7f;
        else shadow_width_cfg = value & 8'h3f;
        @(posedge i_clk);
    endtask

    function automatic t_in random_op();
        int len;
        int pos;
        logic [WIDTH-1:0] key;
        key = key_pool[$urandom_range(0, 7)];
        // mostly related keys so that searches hit, sometimes a fresh tail
        if ($urandom_range(0, 3) == 0) key = key ^ ($urandom() >> $urandom_range(4, 31));
        if ($urandom_range(0, 9) == 0) key = $urandom();
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 32);
        pos = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) :
              $urandom_range(0, shadow_count + 2);
        if ($urandom_range(0, 39) == 0) return op(K_NONE, key, len, pos);
        case ($urandom_range(0, 9))
            0, 1, 2: return op(K_PREFIX, key, len, pos);
            3:       return op(K_EXACT, key, len, pos);
            4:       return op(K_OVERWRITE, key, len, pos);
            5, 6:    return op(K_INSERT, key, len, pos);
            7:       return op(K_INVALIDATE, key, len, pos);
            8:       return op(K_REMOVE, key, len, pos);
            default: return op(K_READ, key, len, pos);
        endcase
    endfunction

    // Result check
    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer %h", o_out);
                failed = 1'b1;
            end else begin
                e = pending_results.pop_front();
                if (o_out.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_out.status);
                    failed = 1'b1;
                end
                if (o_out.hit !== e.hit) begin
                    $error("hit exp %0d got %0d", e.hit, o_out.hit);
                    failed = 1'b1;
                end
                if (o_out.match_index !== e.match_index) begin
                    $error("match_index exp %0d got %0d", e.match_index, o_out.match_index);
                    failed = 1'b1;
                end
                if (o_out.read_bits !== e.read_bits) begin
                    $error("read_bits exp %h got %h", e.read_bits, o_out.read_bits);
                    failed = 1'b1;
                end
                if (o_out.read_length !== e.read_length) begin
                    $error("read_length exp %0d got %0d", e.read_length, o_out.read_length);
                    failed = 1'b1;
                end
            end
        end
    end

    // Receiver stall, with long holds counted here
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Watchdog: any transfer on any channel restarts the count
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[prefix_tcam_table_core] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Empty-table cases, padding, both searches, shifts and unused kind
    task automatic test_basic_ops;
        send_op(op(K_PREFIX, '1, 32, 0));
        send_op(op(K_READ, '0, 0, 63));
        send_op(op(K_INVALIDATE, '0, 0, 3));
        send_op(op(K_REMOVE, '0, 0, 0));
        send_op(op(K_NONE, '1, 63, 63));
        send_op(op(K_OVERWRITE, 32'hA5A5_FFFF, 12, 5));   // pads rows 0..4
        send_op(op(K_READ, '0, 0, 2));
        send_op(op(K_READ, '0, 0, 5));
        send_op(op(K_INSERT, 32'hA000_0000, 3, 0));
        send_op(op(K_INSERT, '1, 32, 2));
        send_op(op(K_INSERT, '0, 0, 9));                   // pads past count
        send_op(op(K_PREFIX, 32'hA5A5_1234, 33, 0));
        send_op(op(K_PREFIX, 32'hA5A5_1234, 63, 0));
        send_op(op(K_EXACT, 32'hA5A5_0000, 12, 0));
        send_op(op(K_EXACT, 32'hA5A5_0000, 40, 0));
        send_op(op(K_EXACT, '1, 32, 0));
        send_op(op(K_PREFIX, '0, 0, 0));
        send_op(op(K_OVERWRITE, '1, 33, 1));               // too wide
        send_op(op(K_INVALIDATE, '0, 0, 0));
        send_op(op(K_PREFIX, 32'hA5A5_0000, 16, 0));
        send_op(op(K_REMOVE, '0, 0, 0));
        send_op(op(K_REMOVE, '0, 0, 42));
        send_op(op(K_READ, '0, 0, 1));
        drain();
    endtask

    // Limit registers at their extremes and the order of the write checks
    task automatic test_limits;
        write_reg(CFG_ROWS, 1);
        write_reg(CFG_WIDTH, 1);
        send_op(op(K_OVERWRITE, '1, 2, 1));   // beyond wins over full and wide
        send_op(op(K_INSERT, '1, 1, 0));      // full
        send_op(op(K_OVERWRITE, '1, 2, 0));   // wide
        send_op(op(K_OVERWRITE, '1, 1, 0));   // overwrite while full
        send_op(op(K_READ, '0, 0, 0));
        drain();
        write_reg(CFG_ROWS, 0);
        send_op(op(K_OVERWRITE, '0, 0, 0));
        drain();
        write_reg(CFG_ROWS, 127);
        write_reg(CFG_WIDTH, 63);
        send_op(op(K_OVERWRITE, 32'h8000_0001, 32, 63));
        send_op(op(K_INSERT, '1, 1, 10));
        send_op(op(K_OVERWRITE, 32'h1234_5678, 32, 63));
        send_op(op(K_READ, '0, 0, 63));
        for (int i = 0; i < 64; i++) send_op(op(K_REMOVE, '0, 0, 0));
        drain();
        write_reg(CFG_ROWS, 64);
        write_reg(CFG_WIDTH, 32);
        drain();
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    task automatic test_backpressure;
        hold_request = 300;
        for (int i = 0; i < 24; i++) send_op(random_op());
        drain();
    endtask

    task automatic test_random(input int count, input int gap, input int stall);
        send_gap_pct = gap;
        stall_pct = stall;
        write_reg(CFG_ROWS, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 127) : 64);
        write_reg(CFG_WIDTH, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : 32);
        for (int i = 0; i < count; i++) send_op(random_op());
        drain();
    endtask

    initial begin
        failed = 1'b0;
        hold_request = 0;
        hold_left = 0;
        quiet_cycles = 0;
        send_gap_pct = 0;
        stall_pct = 0;
        shadow_count = 0;
        shadow_rows_cfg = 64;
        shadow_width_cfg = 32;
        for (int i = 0; i < DEPTH; i++) begin
            shadow_bits[i] = '0;
            shadow_len[i] = '0;
            shadow_valid[i] = 1'b0;
        end
        for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in <= '0;
        i_out_stall <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= 1'b0;
        i_cfg_data <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_ops();
        test_limits();
        test_random(70, 9, 72);
        test_random(70, 9, 72);
        test_random(70, 72, 9);
        test_random(70, 72, 9);
        test_backpressure();
        test_random(70, 0, 0);
        test_random(70, 0, 0);

        repeat (20) @(posedge i_clk);
        if (!failed && pending_results.size() == 0) begin
            $display("[prefix_tcam_table_core] OK");
        end else begin
            $display("[prefix_tcam_table_core] ERROR");
        end
        $finish;
    end
endmodule
